@@ hw/rtl/bolq_pkg.sv @@
// bolq_pkg: types, sizes and helpers for the bucketed open list queue
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package bolq_pkg;

  localparam int ROWS      = 64;
  localparam int ROW_DEPTH = 64;
  localparam int SLOTS     = ROWS * ROW_DEPTH;
  localparam int ROW_W     = $clog2(ROWS);
  localparam int DEPTH_W   = $clog2(ROW_DEPTH);
  localparam int FILL_W    = $clog2(ROW_DEPTH + 1);
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int COUNT_W   = 13;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_UPDATED  = 3'd1,
    ST_MOVED    = 3'd2,
    ST_IGNORED  = 3'd3,
    ST_POPPED   = 3'd4,
    ST_EMPTY    = 3'd5,
    ST_FULL     = 3'd6
  } status_t;

  typedef enum logic {
    REQ_ADD = 1'b0,
    REQ_POP = 1'b1
  } req_kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FILL,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_WRITE,
    S_PSCAN,
    S_PDEC,
    S_PSHIFT,
    S_PFIN,
    S_DONE
  } state_t;

  typedef struct packed {
    req_kind_t    req_type;
    logic [5:0]   row;
    logic [5:0]   col;
    logic [23:0]  f_cost;
    logic [23:0]  g_cost;
    logic [15:0]  radius;
    logic [5:0]   parent_row;
    logic [5:0]   parent_col;
  } req_t;

  typedef struct packed {
    logic [5:0]   col;
    logic [5:0]   parent_row;
    logic [5:0]   parent_col;
    logic [23:0]  f;
    logic [23:0]  g;
    logic [15:0]  radius;
  } entry_t;

  typedef struct packed {
    status_t              status;
    logic [5:0]           out_row;
    entry_t               e;
    logic [COUNT_W-1:0]   node_count;
  } result_t;

  // slot k of row r
  function automatic logic [SLOT_W-1:0] slot_of(input logic [ROW_W-1:0] r,
                                                 input logic [DEPTH_W-1:0] k);
    slot_of = SLOT_W'(SLOT_W'(r) * SLOT_W'(ROW_DEPTH)) + SLOT_W'(k);
  endfunction

endpackage

@@ hw/rtl/bolq_entry_ram.sv @@
// bolq_entry_ram: entry store, one write port and one registered read port
// depends on bolq_pkg for the entry type and address width
`timescale 1ns / 1ps

module bolq_entry_ram
  import bolq_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [SLOT_W-1:0] waddr,
  input  entry_t            wdata,
  input  logic [SLOT_W-1:0] raddr,
  output entry_t            rdata
);

  entry_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/bolq_seq.sv @@
// bolq_seq: sequencer for add and pop, with the row fill store
// depends on bolq_pkg and bolq_entry_ram
`timescale 1ns / 1ps

module bolq_seq
  import bolq_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  req_t    req,
  input  logic    res_ready,
  output logic    idle,
  output logic    done,
  output result_t res
);

  state_t state, state_next;

  req_t                req_q, req_q_next;
  logic [FILL_W-1:0]   fill_q, fill_q_next;
  logic [FILL_W-1:0]   pos, pos_next;
  logic                slot_found, slot_found_next;
  logic                have_match, have_match_next;
  logic [DEPTH_W-1:0]  match_k, match_k_next;
  logic [23:0]         match_f, match_f_next;
  logic [FILL_W-1:0]   k, k_next;
  logic [ROW_W-1:0]    ev_r, ev_r_next;
  status_t             status_q, status_q_next;
  logic                have, have_next;
  logic [ROW_W-1:0]    best_row, best_row_next;
  entry_t              best_e, best_e_next;
  logic [FILL_W-1:0]   best_fill, best_fill_next;
  logic [COUNT_W-1:0]  node_count, node_count_next;

  // entry store port
  logic                ram_we;
  logic [SLOT_W-1:0]   ram_waddr, ram_raddr;
  entry_t              ram_wdata, cur_e;

  // row fill store, valid flag per row stands in for the reset value
  logic [FILL_W-1:0]   fill_mem [ROWS];
  logic [ROWS-1:0]     fill_vld;
  logic                fill_we;
  logic [ROW_W-1:0]    fill_waddr, fill_raddr;
  logic [FILL_W-1:0]   fill_wdata, fill_rd, fill_val;
  logic                vld_rd;

  logic [ROW_W-1:0]    row_idx;
  entry_t              new_e;
  logic                f_ge, col_eq, last_eval, head_better, row_bad;

  bolq_entry_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (cur_e)
  );

  always_ff @(posedge clk) begin
    if (fill_we) begin
      fill_mem[fill_waddr] <= fill_wdata;
    end
    fill_rd <= fill_mem[fill_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_vld <= '0;
      vld_rd   <= 1'b0;
    end else begin
      if (fill_we) begin
        fill_vld[fill_waddr] <= 1'b1;
      end
      vld_rd <= fill_vld[fill_raddr];
    end
  end

  assign fill_val  = vld_rd ? fill_rd : '0;
  assign row_idx   = ROW_W'(req_q.row);
  assign new_e     = '{col: req_q.col, parent_row: req_q.parent_row,
                       parent_col: req_q.parent_col, f: req_q.f_cost,
                       g: req_q.g_cost, radius: req_q.radius};
  assign f_ge      = cur_e.f >= req_q.f_cost;
  assign col_eq    = cur_e.col == req_q.col;
  assign last_eval = (k + FILL_W'(1)) == fill_q;
  assign row_bad   = 32'(req.row) >= ROWS;
  // later row wins a tie on f when its g is not lower
  assign head_better = (fill_val != '0) &&
                       (!have || (cur_e.f < best_e.f) ||
                        ((cur_e.f == best_e.f) && (cur_e.g >= best_e.g)));

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      node_count <= '0;
      have       <= 1'b0;
    end else begin
      state      <= state_next;
      node_count <= node_count_next;
      have       <= have_next;
    end
  end

  always_ff @(posedge clk) begin
    req_q      <= req_q_next;
    fill_q     <= fill_q_next;
    pos        <= pos_next;
    slot_found <= slot_found_next;
    have_match <= have_match_next;
    match_k    <= match_k_next;
    match_f    <= match_f_next;
    k          <= k_next;
    ev_r       <= ev_r_next;
    status_q   <= status_q_next;
    best_row   <= best_row_next;
    best_e     <= best_e_next;
    best_fill  <= best_fill_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (req.req_type == REQ_POP) state_next = S_PSCAN;
          else if (row_bad)            state_next = S_DONE;
          else                         state_next = S_FILL;
        end
      end
      S_FILL:   state_next = (fill_val == '0) ? S_DECIDE : S_SCAN;
      S_SCAN:   if (col_eq || last_eval) state_next = S_DECIDE;
      S_DECIDE: begin
        if (have_match) begin
          if (req_q.f_cost >= match_f)      state_next = S_DONE;
          else if (pos == FILL_W'(match_k)) state_next = S_WRITE;
          else                              state_next = S_SHIFT;
        end else begin
          if (fill_q >= FILL_W'(ROW_DEPTH)) state_next = S_DONE;
          else if (pos == fill_q)           state_next = S_WRITE;
          else                              state_next = S_SHIFT;
        end
      end
      S_SHIFT:  if ((k - FILL_W'(1)) == pos) state_next = S_WRITE;
      S_WRITE:  state_next = S_DONE;
      S_PSCAN:  if (ev_r == ROW_W'(ROWS - 1)) state_next = S_PDEC;
      S_PDEC: begin
        if (!have)                         state_next = S_DONE;
        else if (best_fill > FILL_W'(1))   state_next = S_PSHIFT;
        else                               state_next = S_PFIN;
      end
      S_PSHIFT: if ((k + FILL_W'(2)) == best_fill) state_next = S_PFIN;
      S_PFIN:   state_next = S_DONE;
      S_DONE:   if (res_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_q_next      = req_q;
    fill_q_next     = fill_q;
    pos_next        = pos;
    slot_found_next = slot_found;
    have_match_next = have_match;
    match_k_next    = match_k;
    match_f_next    = match_f;
    k_next          = k;
    ev_r_next       = ev_r;
    status_q_next   = status_q;
    have_next       = have;
    best_row_next   = best_row;
    best_e_next     = best_e;
    best_fill_next  = best_fill;
    node_count_next = node_count;
    ram_we          = 1'b0;
    ram_waddr       = slot_of(row_idx, pos[DEPTH_W-1:0]);
    ram_wdata       = new_e;
    ram_raddr       = '0;
    fill_we         = 1'b0;
    fill_waddr      = row_idx;
    fill_wdata      = fill_q + FILL_W'(1);
    fill_raddr      = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          req_q_next      = req;
          slot_found_next = 1'b0;
          have_match_next = 1'b0;
          have_next       = 1'b0;
          ev_r_next       = '0;
          status_q_next   = ST_FULL;
          if (req.req_type == REQ_ADD) fill_raddr = ROW_W'(req.row);
        end
      end
      S_FILL: begin
        fill_q_next = fill_val;
        pos_next    = fill_val;
        k_next      = '0;
        ram_raddr   = slot_of(row_idx, '0);
      end
      S_SCAN: begin
        ram_raddr = slot_of(row_idx, DEPTH_W'(k + FILL_W'(1)));
        if (!slot_found && f_ge) begin
          pos_next        = k;
          slot_found_next = 1'b1;
        end
        if (col_eq) begin
          have_match_next = 1'b1;
          match_k_next    = k[DEPTH_W-1:0];
          match_f_next    = cur_e.f;
        end
        k_next = k + FILL_W'(1);
      end
      S_DECIDE: begin
        if (have_match) begin
          if (req_q.f_cost >= match_f) begin
            status_q_next = ST_IGNORED;
          end else if (pos == FILL_W'(match_k)) begin
            status_q_next = ST_UPDATED;
          end else begin
            status_q_next = ST_MOVED;
            ram_raddr     = slot_of(row_idx, match_k - DEPTH_W'(1));
            k_next        = FILL_W'(match_k);
          end
        end else begin
          if (fill_q >= FILL_W'(ROW_DEPTH)) begin
            status_q_next = ST_FULL;
          end else begin
            status_q_next = ST_INSERTED;
            ram_raddr     = slot_of(row_idx, DEPTH_W'(fill_q - FILL_W'(1)));
            k_next        = fill_q;
          end
        end
      end
      S_SHIFT: begin
        // entry k-1 read last cycle lands in slot k
        ram_we    = 1'b1;
        ram_waddr = slot_of(row_idx, k[DEPTH_W-1:0]);
        ram_wdata = cur_e;
        ram_raddr = slot_of(row_idx, DEPTH_W'(k - FILL_W'(2)));
        k_next    = k - FILL_W'(1);
      end
      S_WRITE: begin
        ram_we = 1'b1;
        if (status_q == ST_INSERTED) begin
          fill_we         = 1'b1;
          node_count_next = node_count + COUNT_W'(1);
        end
      end
      S_PSCAN: begin
        fill_raddr = ev_r + ROW_W'(1);
        ram_raddr  = slot_of(ev_r + ROW_W'(1), '0);
        if (head_better) begin
          have_next      = 1'b1;
          best_row_next  = ev_r;
          best_e_next    = cur_e;
          best_fill_next = fill_val;
        end
        ev_r_next = ev_r + ROW_W'(1);
      end
      S_PDEC: begin
        status_q_next = have ? ST_POPPED : ST_EMPTY;
        ram_raddr     = slot_of(best_row, DEPTH_W'(1));
        k_next        = '0;
      end
      S_PSHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = slot_of(best_row, k[DEPTH_W-1:0]);
        ram_wdata = cur_e;
        ram_raddr = slot_of(best_row, DEPTH_W'(k + FILL_W'(2)));
        k_next    = k + FILL_W'(1);
      end
      S_PFIN: begin
        fill_we         = 1'b1;
        fill_waddr      = best_row;
        fill_wdata      = best_fill - FILL_W'(1);
        node_count_next = node_count - COUNT_W'(1);
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    idle           = state == S_IDLE;
    done           = state == S_DONE;
    res            = '0;
    res.status     = status_q;
    res.node_count = node_count;
    if (status_q == ST_POPPED) begin
      res.out_row = 6'(best_row);
      res.e       = best_e;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(node_count) <= SLOTS) else $error("node count beyond capacity");
  a_start_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && start) |=> state != S_IDLE) else $error("start lost");
  a_pop_has_winner: assert property (@(posedge clk) disable iff (rst)
    (state == S_PFIN) |-> (have && best_fill != '0)) else $error("pop with no head");
  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE && status_q == ST_INSERTED) |-> fill_q < FILL_W'(ROW_DEPTH))
    else $error("insert into full row");
`endif

endmodule

@@ hw/rtl/bucketed_open_list_queue_core.sv @@
// bucketed open list queue: an add scans the row, then shifts entries up one slot through the
// single read port and writes the new entry; an ignored add or a full row ends at the decision
// a pop scans every row head, shifts the winning row down and lowers its fill, if any
// one beat at a time, the next taken in the cycle after the result is loaded; a result
// register lets the next beat in while one waits
// synchronous reset clears control and the row fill flags, no sweep
`timescale 1ns / 1ps

module bucketed_open_list_queue_core
  import bolq_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  logic                req_type,
  input  logic [5:0]          row,
  input  logic [5:0]          col,
  input  logic [23:0]         f_cost,
  input  logic [23:0]         g_cost,
  input  logic [15:0]         radius,
  input  logic [5:0]          parent_row,
  input  logic [5:0]          parent_col,
  output logic                res_valid,
  input  logic                res_stall,
  output logic [2:0]          status,
  output logic [5:0]          out_row,
  output logic [5:0]          out_col,
  output logic [23:0]         out_f,
  output logic [23:0]         out_g,
  output logic [15:0]         out_radius,
  output logic [5:0]          out_parent_row,
  output logic [5:0]          out_parent_col,
  output logic [COUNT_W-1:0]  node_count
);

  logic    seq_idle, seq_done, start, res_ready;
  req_t    req;
  result_t seq_res, res_q;

  assign req_stall = rst || !seq_idle;
  assign start     = req_valid && !req_stall;
  assign res_ready = !res_valid || !res_stall;
  assign req       = '{req_type: req_kind_t'(req_type), row: row, col: col,
                       f_cost: f_cost, g_cost: g_cost, radius: radius,
                       parent_row: parent_row, parent_col: parent_col};

  bolq_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req       (req),
    .res_ready (res_ready),
    .idle      (seq_idle),
    .done      (seq_done),
    .res       (seq_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (seq_done && res_ready) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_done && res_ready) begin
      res_q <= seq_res;
    end
  end

  assign status         = res_q.status;
  assign out_row        = res_q.out_row;
  assign out_col        = res_q.e.col;
  assign out_f          = res_q.e.f;
  assign out_g          = res_q.e.g;
  assign out_radius     = res_q.e.radius;
  assign out_parent_row = res_q.e.parent_row;
  assign out_parent_col = res_q.e.parent_col;
  assign node_count     = res_q.node_count;

endmodule
